FILE: design/i2c_tc_pkg.sv
// Shared types and constants for the I2C target controller.
package i2c_tc_pkg;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_ADDR      = 4'd1,
      PH_FOREIGN   = 4'd2,
      PH_ADDR_ACK  = 4'd3,
      PH_RX        = 4'd4,
      PH_RX_ACK    = 4'd5,
      PH_TX        = 4'd6,
      PH_TX_ACK    = 4'd7,
      PH_TX_NEXT   = 4'd8,
      PH_WAIT_STOP = 4'd9
   } phase_type;

   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_WRITE = 3'd1;
   localparam logic [2:0] EV_READ  = 3'd2;
   localparam logic [2:0] EV_END   = 3'd3;
   localparam logic [2:0] EV_NACK  = 3'd4;

   localparam logic [0:0] CSR_OWN_ADDRESS    = 1'd0;
   localparam logic [0:0] CSR_TRANSFER_LIMIT = 1'd1;

   localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
   localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic       last_scl;
      logic       last_sda;
      phase_type  phase;
      logic [3:0] bit_index;
      logic [7:0] shift_reg;
      logic       read_direction;
      logic       drive_low;
   } bus_state_type;

   typedef struct packed {
      logic       sda_pull_low;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       tx_taken;
      logic [2:0] event_res;
   } result_type;

endpackage

FILE: design/i2c_target_controller_core.sv
// I2C target controller: one pin sample in per beat, one line/status result out per beat.
// A result is registered and appears on rsp in the cycle after its sample beat is accepted.
// Throughput: one sample beat per cycle while the result register is empty or draining.
// Reset is synchronous and active high: the bus state returns to idle with both
// last levels high, the result register empties, own_address reads 0 and
// transfer_limit reads 0xFFFF.
module i2c_target_controller_core
   import i2c_tc_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] scl_level, [1] sda_level, [9:2] tx_byte, [15:10] zero
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] sda_pull_low, [1] rx_valid, [9:2] rx_byte, [10] tx_taken,
   // [13:11] event_res, [29:14] byte_count, [31:30] zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   logic [6:0]            own_address_ff;
   logic [15:0]           limit_ff;
   bus_state_type         state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   result_type            result;
   logic                  accept, can_load;
   logic [CMP_W-1:0]      count_wide;

   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= 7'd0;
         limit_ff       <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:    own_address_ff <= csr_wdata[6:0];
            CSR_TRANSFER_LIMIT: limit_ff       <= csr_wdata;
            default:            limit_ff       <= limit_ff;
         endcase
      end
   end

   i2c_tc_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .cur_state      (state_ff),
      .cur_count      (count_ff),
      .scl            (req_tdata[0]),
      .sda            (req_tdata[1]),
      .tx_byte        (req_tdata[9:2]),
      .own_address    (own_address_ff),
      .transfer_limit (limit_ff),
      .nxt_state      (state_in),
      .nxt_count      (count_in),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.last_scl       <= 1'b1;
         state_ff.last_sda       <= 1'b1;
         state_ff.phase          <= PH_IDLE;
         state_ff.bit_index      <= 4'd0;
         state_ff.shift_reg      <= 8'd0;
         state_ff.read_direction <= 1'b0;
         state_ff.drive_low      <= 1'b0;
         count_ff                <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign count_wide = CMP_W'(count_in);

   i2c_tc_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .byte_count (count_wide[15:0]),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: design/i2c_tc_step.sv
// Combinational next-state and result logic for one sample of SCL and SDA.
module i2c_tc_step
   import i2c_tc_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  bus_state_type           cur_state,
   input  logic [COUNT_BITS-1:0]   cur_count,
   input  logic                    scl,
   input  logic                    sda,
   input  logic [7:0]              tx_byte,
   input  logic [6:0]              own_address,
   input  logic [15:0]             transfer_limit,
   output bus_state_type           nxt_state,
   output logic [COUNT_BITS-1:0]   nxt_count,
   output result_type              result
);

   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   logic rise, fall, high, start_cond, stop_cond;
   logic byte_done, can_move, addr_match, addressed;
   logic [COUNT_BITS-1:0] count_inc;
   phase_type nxt_phase;

   assign rise = !cur_state.last_scl && scl;
   assign fall = cur_state.last_scl && !scl;
   assign high = cur_state.last_scl && scl;
   assign start_cond = high && cur_state.last_sda && !sda;
   assign stop_cond  = high && !cur_state.last_sda && sda;
   assign byte_done  = cur_state.bit_index >= BITS_PER_BYTE;
   assign can_move   = CMP_W'(cur_count) < CMP_W'(transfer_limit);
   assign addr_match = cur_state.shift_reg[7:1] == own_address;
   assign addressed  = (cur_state.phase == PH_ADDR_ACK) || (cur_state.phase == PH_RX)
                    || (cur_state.phase == PH_RX_ACK) || (cur_state.phase == PH_TX)
                    || (cur_state.phase == PH_TX_ACK) || (cur_state.phase == PH_TX_NEXT)
                    || (cur_state.phase == PH_WAIT_STOP);
   // The byte counter saturates rather than wrapping.
   assign count_inc = (cur_count == {COUNT_BITS{1'b1}}) ? cur_count
                                                        : cur_count + COUNT_BITS'(1);

   // Next phase.
   always_comb begin
      nxt_phase = cur_state.phase;
      priority if (start_cond) begin
         nxt_phase = PH_ADDR;
      end else if (stop_cond) begin
         nxt_phase = PH_IDLE;
      end else begin
         unique case (cur_state.phase)
            PH_ADDR: begin
               if (fall && byte_done) nxt_phase = addr_match ? PH_ADDR_ACK : PH_FOREIGN;
            end
            PH_ADDR_ACK: begin
               if (fall) begin
                  if (cur_state.read_direction) begin
                     nxt_phase = can_move ? PH_TX : PH_WAIT_STOP;
                  end else begin
                     nxt_phase = PH_RX;
                  end
               end
            end
            PH_RX: begin
               if (fall && byte_done) nxt_phase = can_move ? PH_RX_ACK : PH_WAIT_STOP;
            end
            PH_RX_ACK: begin
               if (fall) nxt_phase = PH_RX;
            end
            PH_TX: begin
               if (fall && byte_done) nxt_phase = PH_TX_ACK;
            end
            PH_TX_ACK: begin
               if (rise) nxt_phase = sda ? PH_WAIT_STOP : PH_TX_NEXT;
            end
            PH_TX_NEXT: begin
               if (fall) nxt_phase = can_move ? PH_TX : PH_WAIT_STOP;
            end
            default: nxt_phase = cur_state.phase;
         endcase
      end
   end

   // Shift register, counters, line drive and result fields.
   always_comb begin
      nxt_state.phase          = nxt_phase;
      nxt_state.last_scl       = scl;
      nxt_state.last_sda       = sda;
      nxt_state.bit_index      = cur_state.bit_index;
      nxt_state.shift_reg      = cur_state.shift_reg;
      nxt_state.read_direction = cur_state.read_direction;
      nxt_state.drive_low      = cur_state.drive_low;
      nxt_count                = cur_count;
      result.rx_valid          = 1'b0;
      result.rx_byte           = 8'd0;
      result.tx_taken          = 1'b0;
      result.event_res         = EV_NONE;
      priority if (start_cond) begin
         if (addressed) result.event_res = EV_END;
         nxt_state.bit_index      = 4'd0;
         nxt_state.shift_reg      = 8'd0;
         nxt_state.drive_low      = 1'b0;
         nxt_state.read_direction = 1'b0;
         nxt_count                = '0;
      end else if (stop_cond) begin
         if (addressed) result.event_res = EV_END;
         nxt_state.bit_index = 4'd0;
         nxt_state.drive_low = 1'b0;
      end else begin
         unique case (cur_state.phase)
            PH_ADDR, PH_RX: begin
               if (rise) begin
                  nxt_state.shift_reg = {cur_state.shift_reg[6:0], sda};
                  if (!byte_done) nxt_state.bit_index = cur_state.bit_index + 4'd1;
               end else if (fall && byte_done) begin
                  if (cur_state.phase == PH_ADDR) begin
                     if (addr_match) begin
                        nxt_state.read_direction = cur_state.shift_reg[0];
                        nxt_state.drive_low      = 1'b1;
                        result.event_res = cur_state.shift_reg[0] ? EV_READ : EV_WRITE;
                     end
                  end else if (can_move) begin
                     nxt_state.drive_low = 1'b1;
                     result.rx_valid     = 1'b1;
                     result.rx_byte      = cur_state.shift_reg;
                     nxt_count           = count_inc;
                  end else begin
                     nxt_state.drive_low = 1'b0;
                  end
               end
            end
            PH_ADDR_ACK, PH_TX_NEXT: begin
               if (fall) begin
                  if (cur_state.phase == PH_ADDR_ACK && !cur_state.read_direction) begin
                     nxt_state.drive_low = 1'b0;
                     nxt_state.bit_index = 4'd0;
                     nxt_state.shift_reg = 8'd0;
                  end else if (can_move) begin
                     // Load the next transmit byte and put its MSB on the line.
                     nxt_state.shift_reg = tx_byte;
                     result.tx_taken     = 1'b1;
                     nxt_state.drive_low = !tx_byte[7];
                     nxt_state.bit_index = 4'd0;
                  end else begin
                     nxt_state.drive_low = 1'b0;
                  end
               end
            end
            PH_RX_ACK: begin
               if (fall) begin
                  nxt_state.drive_low = 1'b0;
                  nxt_state.bit_index = 4'd0;
                  nxt_state.shift_reg = 8'd0;
               end
            end
            PH_TX: begin
               if (rise) begin
                  if (!byte_done) nxt_state.bit_index = cur_state.bit_index + 4'd1;
               end else if (fall) begin
                  if (byte_done) begin
                     nxt_state.drive_low = 1'b0;
                     nxt_count           = count_inc;
                  end else begin
                     nxt_state.shift_reg = {cur_state.shift_reg[6:0], 1'b0};
                     nxt_state.drive_low = !cur_state.shift_reg[6];
                  end
               end
            end
            PH_TX_ACK: begin
               if (rise && sda) result.event_res = EV_NACK;
            end
            default: nxt_state.drive_low = cur_state.drive_low;
         endcase
      end
      result.sda_pull_low = nxt_state.drive_low;
   end

endmodule

FILE: design/i2c_tc_out_reg.sv
// Result register with its output handshake for the I2C target controller.
module i2c_tc_out_reg
   import i2c_tc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  result,
   input  logic [15:0] byte_count,
   output logic        can_load,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata
);

   logic        valid_ff, valid_in;
   result_type  result_ff;
   logic [15:0] count_ff;

   // A new beat may enter while the held one leaves in the same cycle.
   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
         count_ff  <= byte_count;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, count_ff, result_ff.event_res, result_ff.tx_taken,
                        result_ff.rx_byte, result_ff.rx_valid, result_ff.sda_pull_low};

endmodule

FILE: design/i2c_tc_checker.sv
// Port-level assertions for the I2C target controller, bound to the top level.
module i2c_tc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A held result beat must not change until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // With the result register empty the block must take samples.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("sample beat refused with empty result register");

   // A received byte is never reported together with a bus event.
   a_rx_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[13:11] == 3'd0)
      else $error("received byte coincides with an event");

   // The received byte field is zero unless a byte is reported.
   a_rx_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[9:2] == 8'd0)
      else $error("received byte field not zero without rx_valid");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

endmodule

bind i2c_target_controller_core i2c_tc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the I2C target controller core, driven by bus-level pin samples.
module testbench;
   import i2c_tc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // One result beat, fields from the top bit down.
   typedef struct packed {
      logic [1:0]  pad;
      logic [15:0] byte_count;
      logic [2:0]  event_res;
      logic        tx_taken;
      logic [7:0]  rx_byte;
      logic        rx_valid;
      logic        sda_pull_low;
   } status_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   i2c_target_controller_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Target state as the bus should leave it, plus the register copies.
   logic        tgt_last_scl = 1'b1;
   logic        tgt_last_sda = 1'b1;
   phase_type   tgt_phase = PH_IDLE;
   logic [3:0]  tgt_bits = '0;
   logic [7:0]  tgt_shift = '0;
   logic        tgt_read = 1'b0;
   logic [15:0] tgt_count = '0;
   logic        tgt_drive = 1'b0;
   logic [6:0]  cfg_address = '0;
   logic [15:0] cfg_limit = LIMIT_RESET;

   status_word_type expected_status[$];

   int send_idle_pct = 17;
   int recv_stall_pct = 84;
   int hold_max = 1;
   int tx_fixed = -1;
   int samples_sent = 0;
   int transactions = 0;
   int results_checked = 0;
   int mismatches = 0;
   int cycles = 0;
   int rx_bytes_seen = 0;
   int tx_loads_seen = 0;
   int events_seen[5] = '{default: 0};

   task automatic load_next_byte(input logic [7:0] tx, inout logic taken);
      if (tgt_count < cfg_limit) begin
         tgt_shift = tx;
         taken = 1'b1;
         tgt_drive = ~tx[7];
         tgt_bits = '0;
         tgt_phase = PH_TX;
      end else begin
         tgt_drive = 1'b0;
         tgt_phase = PH_WAIT_STOP;
      end
   endtask

   task automatic predict_line_status(input logic scl, input logic sda, input logic [7:0] tx,
                                      output status_word_type res);
      logic       rise, fall, high, rxv, taken, addressed;
      logic [7:0] rxb;
      logic [2:0] ev;
      rise = !tgt_last_scl && scl;
      fall = tgt_last_scl && !scl;
      high = tgt_last_scl && scl;
      addressed = (tgt_phase >= PH_ADDR_ACK) && (tgt_phase <= PH_WAIT_STOP);
      rxv = 1'b0;
      rxb = '0;
      taken = 1'b0;
      ev = EV_NONE;
      if (high && tgt_last_sda && !sda) begin
         // Start or repeated start: ends any transaction we were part of.
         if (addressed) ev = EV_END;
         tgt_phase = PH_ADDR;
         tgt_bits = '0;
         tgt_shift = '0;
         tgt_drive = 1'b0;
         tgt_count = '0;
         tgt_read = 1'b0;
      end else if (high && !tgt_last_sda && sda) begin
         if (addressed) ev = EV_END;
         tgt_phase = PH_IDLE;
         tgt_bits = '0;
         tgt_drive = 1'b0;
      end else begin
         case (tgt_phase)
            PH_ADDR: begin
               if (rise) begin
                  tgt_shift = {tgt_shift[6:0], sda};
                  if (tgt_bits < BITS_PER_BYTE) tgt_bits++;
               end else if (fall && tgt_bits >= BITS_PER_BYTE) begin
                  if (tgt_shift[7:1] == cfg_address) begin
                     tgt_read = tgt_shift[0];
                     tgt_drive = 1'b1;
                     ev = tgt_read ? EV_READ : EV_WRITE;
                     tgt_phase = PH_ADDR_ACK;
                  end else begin
                     tgt_phase = PH_FOREIGN;
                  end
               end
            end
            PH_ADDR_ACK: begin
               if (fall) begin
                  if (tgt_read) begin
                     load_next_byte(tx, taken);
                  end else begin
                     tgt_drive = 1'b0;
                     tgt_bits = '0;
                     tgt_shift = '0;
                     tgt_phase = PH_RX;
                  end
               end
            end
            PH_RX: begin
               if (rise) begin
                  tgt_shift = {tgt_shift[6:0], sda};
                  if (tgt_bits < BITS_PER_BYTE) tgt_bits++;
               end else if (fall && tgt_bits >= BITS_PER_BYTE) begin
                  if (tgt_count < cfg_limit) begin
                     tgt_drive = 1'b1;
                     rxv = 1'b1;
                     rxb = tgt_shift;
                     if (tgt_count != 16'hFFFF) tgt_count++;
                     tgt_phase = PH_RX_ACK;
                  end else begin
                     tgt_drive = 1'b0;
                     tgt_phase = PH_WAIT_STOP;
                  end
               end
            end
            PH_RX_ACK: begin
               if (fall) begin
                  tgt_drive = 1'b0;
                  tgt_bits = '0;
                  tgt_shift = '0;
                  tgt_phase = PH_RX;
               end
            end
            PH_TX: begin
               if (rise) begin
                  if (tgt_bits < BITS_PER_BYTE) tgt_bits++;
               end else if (fall) begin
                  if (tgt_bits >= BITS_PER_BYTE) begin
                     tgt_drive = 1'b0;
                     if (tgt_count != 16'hFFFF) tgt_count++;
                     tgt_phase = PH_TX_ACK;
                  end else begin
                     tgt_shift = tgt_shift << 1;
                     tgt_drive = ~tgt_shift[7];
                  end
               end
            end
            PH_TX_ACK: begin
               if (rise) begin
                  if (sda) begin
                     ev = EV_NACK;
                     tgt_phase = PH_WAIT_STOP;
                  end else begin
                     tgt_phase = PH_TX_NEXT;
                  end
               end
            end
            PH_TX_NEXT: begin
               if (fall) load_next_byte(tx, taken);
            end
            default: ;
         endcase
      end
      tgt_last_scl = scl;
      tgt_last_sda = sda;
      res = '{pad: 2'b00, byte_count: tgt_count, event_res: ev, tx_taken: taken,
              rx_byte: rxb, rx_valid: rxv, sda_pull_low: tgt_drive};
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch at result %0d: %s is %0h, expected %0h",
                  results_checked, what, got, want);
   endtask

   // Sends one pin sample beat; entered and left at a falling edge.
   task automatic send_sample(input logic scl, input logic sda, input logic [7:0] tx);
      status_word_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, tx, sda, scl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_line_status(scl, sda, tx, want);
      expected_status.push_back(want);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic hold(input logic scl, input logic sda);
      int reps;
      reps = $urandom_range(hold_max, 1);
      repeat (reps)
         send_sample(scl, sda, (tx_fixed < 0) ? 8'($urandom_range(255)) : 8'(tx_fixed));
   endtask

   task automatic clock_bit(input logic b);
      hold(1'b0, b);
      hold(1'b1, b);
      hold(1'b0, b);
   endtask

   task automatic master_byte(input logic [7:0] value);
      for (int i = 7; i >= 0; i--) clock_bit(value[i]);
   endtask

   task automatic bus_start;
      transactions++;
      hold(1'b0, 1'b1);
      hold(1'b1, 1'b1);
      hold(1'b1, 1'b0);
      hold(1'b0, 1'b0);
   endtask

   task automatic bus_stop;
      hold(1'b0, 1'b0);
      hold(1'b1, 1'b0);
      hold(1'b1, 1'b1);
   endtask

   // Bits the target owns are sent as the wired-AND level the master would see.
   task automatic transfer(input logic [6:0] addr, input logic rd, input int nbytes,
                           input logic nack_end, input logic end_stop);
      logic [7:0] data;
      bus_start();
      master_byte({addr, rd});
      clock_bit(~tgt_drive);
      for (int n = 0; n < nbytes; n++) begin
         if (rd) begin
            repeat (8) clock_bit(~tgt_drive);
            clock_bit(nack_end && n == nbytes - 1);
         end else begin
            data = (tx_fixed < 0) ? 8'($urandom_range(255)) : 8'(tx_fixed);
            master_byte(data);
            clock_bit(~tgt_drive);
         end
      end
      if (end_stop) bus_stop();
   endtask

   function automatic logic addr_bit(input logic [6:0] addr, input logic rd, input int i);
      logic [7:0] frame;
      frame = {addr, rd};
      return frame[7 - i];
   endfunction

   // A transaction broken off after a given number of bit slots.
   task automatic cut_short(input logic [6:0] addr, input logic rd, input int nbits,
                            input logic with_stop);
      int slot;
      bus_start();
      for (int i = 0; i < nbits; i++) begin
         slot = (i < 9) ? i : (i - 9) % 9;
         if (i < 8) clock_bit(addr_bit(addr, rd, i));
         else if (slot == 8) clock_bit(rd && i > 8 ? 1'($urandom_range(1)) : ~tgt_drive);
         else clock_bit(rd ? ~tgt_drive : 1'($urandom_range(1)));
      end
      if (with_stop) bus_stop();
   endtask

   task automatic wait_drained;
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [0:0] idx, input logic [15:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_OWN_ADDRESS) cfg_address = value[6:0];
      else cfg_limit = value;
   endtask

   task automatic test_default_registers;
      // Address 0 with a byte limit of 0xFFFF until the registers are first written.
      tx_fixed = 8'hFF;
      transfer(7'd0, 1'b0, 1, 1'b0, 1'b1);
      tx_fixed = 8'h00;
      transfer(7'd0, 1'b1, 2, 1'b1, 1'b1);
   endtask

   task automatic test_address_match;
      write_register(CSR_OWN_ADDRESS, 16'd127);
      tx_fixed = 8'hFF;
      transfer(7'd127, 1'b1, 2, 1'b0, 1'b1);
      tx_fixed = 8'h00;
      transfer(7'd127, 1'b0, 1, 1'b0, 1'b1);
      tx_fixed = 8'hA5;
      transfer(7'd0, 1'b0, 1, 1'b0, 1'b1);
      transfer(7'd126, 1'b1, 1, 1'b1, 1'b1);
   endtask

   task automatic test_transfer_limit;
      tx_fixed = 8'h5A;
      write_register(CSR_TRANSFER_LIMIT, 16'd0);
      transfer(7'd127, 1'b0, 1, 1'b0, 1'b1);
      transfer(7'd127, 1'b1, 1, 1'b0, 1'b1);
      write_register(CSR_TRANSFER_LIMIT, 16'd1);
      transfer(7'd127, 1'b0, 2, 1'b0, 1'b1);
      transfer(7'd127, 1'b1, 2, 1'b0, 1'b1);
      write_register(CSR_TRANSFER_LIMIT, LIMIT_RESET);
   endtask

   task automatic test_bus_breaks;
      tx_fixed = -1;
      // Repeated start straight after a write, then stop and start in mid-byte.
      transfer(7'd127, 1'b0, 1, 1'b0, 1'b0);
      transfer(7'd127, 1'b1, 1, 1'b1, 1'b1);
      cut_short(7'd127, 1'b0, 13, 1'b1);
      cut_short(7'd127, 1'b1, 12, 1'b0);
      cut_short(7'd127, 1'b0, 4, 1'b0);
      cut_short(7'd5, 1'b0, 14, 1'b1);
      transfer(7'd127, 1'b0, 1, 1'b0, 1'b1);
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int wanted);
      int first, kind, nbytes;
      logic [6:0] addr;
      send_idle_pct = sender_idle;
      recv_stall_pct = receiver_stall;
      hold_max = 3;
      tx_fixed = -1;
      first = samples_sent;
      while (samples_sent - first < wanted) begin
         kind = $urandom_range(99);
         addr = ($urandom_range(99) < 75) ? cfg_address : 7'($urandom_range(127));
         if (kind < 6) begin
            if ($urandom_range(1)) begin
               case ($urandom_range(2))
                  0: write_register(CSR_OWN_ADDRESS, 16'd0);
                  1: write_register(CSR_OWN_ADDRESS, 16'd127);
                  default: write_register(CSR_OWN_ADDRESS, 16'($urandom_range(127)));
               endcase
            end
            case ($urandom_range(5))
               0: write_register(CSR_TRANSFER_LIMIT, 16'd0);
               1: write_register(CSR_TRANSFER_LIMIT, 16'hFFFF);
               2: write_register(CSR_TRANSFER_LIMIT, 16'($urandom_range(16'hFFFF)));
               default: write_register(CSR_TRANSFER_LIMIT, 16'($urandom_range(4, 1)));
            endcase
         end else if (kind < 78) begin
            nbytes = ($urandom_range(9) == 0) ? $urandom_range(8, 4) : $urandom_range(3);
            transfer(addr, 1'($urandom_range(1)), nbytes, 1'($urandom_range(1)),
                     $urandom_range(99) < 85);
         end else if (kind < 90) begin
            cut_short(addr, 1'($urandom_range(1)), $urandom_range(25), 1'($urandom_range(1)));
         end else begin
            repeat ($urandom_range(12, 1))
               send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                           8'($urandom_range(255)));
         end
      end
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin : check_results
      status_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_status.size() == 0) begin
            report_mismatch("beat with nothing expected", rsp_tdata, '0);
         end else begin
            want = expected_status.pop_front();
            if (got.sda_pull_low !== want.sda_pull_low)
               report_mismatch("sda_pull_low", 32'(got.sda_pull_low),
                               32'(want.sda_pull_low));
            if (got.rx_valid !== want.rx_valid)
               report_mismatch("rx_valid", 32'(got.rx_valid), 32'(want.rx_valid));
            if (got.rx_byte !== want.rx_byte)
               report_mismatch("rx_byte", 32'(got.rx_byte), 32'(want.rx_byte));
            if (got.tx_taken !== want.tx_taken)
               report_mismatch("tx_taken", 32'(got.tx_taken), 32'(want.tx_taken));
            if (got.event_res !== want.event_res)
               report_mismatch("event_res", 32'(got.event_res), 32'(want.event_res));
            if (got.byte_count !== want.byte_count)
               report_mismatch("byte_count", 32'(got.byte_count), 32'(want.byte_count));
            if (want.rx_valid) rx_bytes_seen++;
            if (want.tx_taken) tx_loads_seen++;
            if (want.event_res <= EV_NACK) events_seen[want.event_res]++;
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d results outstanding",
                  cycles, expected_status.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_registers();
      test_address_match();
      test_transfer_limit();
      test_bus_breaks();
      test_random_traffic(17, 84, 200);
      test_random_traffic(84, 17, 200);
      test_random_traffic(0, 0, 200);
      wait_drained();
      $display("Ran %0d pin samples over %0d bus transactions; %0d bytes received, %0d loaded.",
               samples_sent, transactions, rx_bytes_seen, tx_loads_seen);
      $display("Events: %0d write, %0d read, %0d end, %0d master NACK; %0d beats checked.",
               events_seen[EV_WRITE], events_seen[EV_READ], events_seen[EV_END],
               events_seen[EV_NACK], results_checked);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: i2c_target_controller_core.f
design/i2c_tc_pkg.sv
design/i2c_tc_step.sv
design/i2c_tc_out_reg.sv
design/i2c_target_controller_core.sv
design/i2c_tc_checker.sv
tb/sv/testbench.sv
